### src/aba_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the aligned bump allocator.
// No dependencies; imported by every module of the block.
package aba_pkg;

    localparam int ALIGN_W   = 16;   // width of an alignment request
    localparam int CHUNK_W   = 16;   // width of the chunk size register
    localparam int LCM_W     = 32;   // lcm of two 16-bit values always fits
    localparam int ACTION_W  = 2;
    localparam int CFG_IDX_W = 2;

    typedef logic [ACTION_W-1:0]  action_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [ALIGN_W-1:0]   align_t;
    typedef logic [CHUNK_W-1:0]   chunk_t;
    typedef logic [LCM_W-1:0]     lcm_t;

    localparam action_t ACT_APPEND        = 2'd0;
    localparam action_t ACT_CLEAR         = 2'd1;
    localparam action_t ACT_CLEAR_ALIGNED = 2'd2;

    localparam cfg_idx_t REG_BASE     = 2'd0;
    localparam cfg_idx_t REG_CAPACITY = 2'd1;
    localparam cfg_idx_t REG_CHUNK    = 2'd2;

endpackage

### src/aba_gcd.sv
`timescale 1ns / 1ps
// Binary (shift and subtract) greatest common divisor, one step per cycle.
// Depends on aba_pkg; both operands must be nonzero.
module aba_gcd
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           go,
    input  aba_pkg::align_t a,
    input  aba_pkg::chunk_t b,
    output logic           done,
    output aba_pkg::align_t g
);
    import aba_pkg::*;

    localparam int KW = $clog2(ALIGN_W + 1);

    align_t        a_reg, a_next;
    align_t        b_reg, b_next;
    logic [KW-1:0] k_reg, k_next;
    logic          run_reg, run_next;
    logic          done_reg, done_next;
    align_t        g_reg, g_next;

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        k_next    = k_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        g_next    = g_reg;
        if (go)
        begin
            a_next   = a;
            b_next   = b;
            k_next   = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (a_reg == b_reg)
            begin
                g_next    = a_reg << k_reg;
                run_next  = 1'b0;
                done_next = 1'b1;
            end
            else if (!a_reg[0] && !b_reg[0])
            begin
                a_next = a_reg >> 1;
                b_next = b_reg >> 1;
                k_next = k_reg + 1'b1;
            end
            else if (!a_reg[0])
            begin
                a_next = a_reg >> 1;
            end
            else if (!b_reg[0])
            begin
                b_next = b_reg >> 1;
            end
            else if (a_reg > b_reg)
            begin
                a_next = (a_reg - b_reg) >> 1;
            end
            else
            begin
                b_next = (b_reg - a_reg) >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        k_reg <= k_next;
        g_reg <= g_next;
    end

    assign done = done_reg;
    assign g    = g_reg;

endmodule

### src/aba_serial_div.sv
`timescale 1ns / 1ps
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
// Depends on aba_pkg. The dividend is loaded left aligned; len bits are consumed.
module aba_serial_div
#(
    parameter int DW = 32,
    parameter int RW = 32,
    localparam int CW = $clog2(DW + 1)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          go,
    input  logic [CW-1:0] len,
    input  logic [DW-1:0] dividend,
    input  logic [RW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient,
    output logic [RW-1:0] remainder
);
    import aba_pkg::*;

    logic [DW-1:0] dvd_reg, dvd_next;
    logic [RW-1:0] dvs_reg, dvs_next;
    logic [RW-1:0] rem_reg, rem_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          run_reg, run_next;
    logic          done_reg, done_next;
    logic [RW:0]   trial;

    assign trial = {rem_reg, dvd_reg[DW-1]};

    always_comb
    begin
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (go)
        begin
            dvd_next = dividend;
            dvs_next = divisor;
            rem_next = '0;
            cnt_next = len;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = RW'(trial - {1'b0, dvs_reg});
                dvd_next = {dvd_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[RW-1:0];
                dvd_next = {dvd_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = dvd_reg;
    assign remainder = rem_reg;

endmodule

### src/aligned_bump_allocator.sv
`timescale 1ns / 1ps
// Top level of the aligned bump allocator: sequencer, state and configuration.
// Depends on aba_pkg, aba_gcd and aba_serial_div.
//
// A request is taken at a clock edge where start is high and busy is low; busy
// then stays high until the single result appears on the result ports with done
// high for exactly one cycle, and the receiver must take it then because there
// is no way to hold it off. A new request may be given in the very cycle in
// which done is high. The work is done bit by bit in one shared serial divider
// and a binary gcd unit, so the time per request is set by that divider. A plain
// clear or an unknown action only works out the remaining-space figure, and so
// does an append that finds no usable pool or asks for zero bytes, or an aligned
// clear that finds no usable pool. Otherwise an append runs the gcd, then a
// division and a bit-serial multiply for the lcm, then divisions for the padding
// and for the request in chunks; a clear to an aligned position runs the gcd and
// the lcm, the padding division twice and a division that checks the alignment.
// Configuration writes take effect at once and should only be made while busy
// is low.
module aligned_bump_allocator
#(
    parameter int SIZE_BITS = 24,
    parameter int ADDR_BITS = 32,
    localparam int CFG_W = (ADDR_BITS > SIZE_BITS) ? ADDR_BITS : SIZE_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  aba_pkg::action_t      action,
    input  logic [SIZE_BITS-1:0]  request_bytes,
    input  aba_pkg::align_t       align_bytes,
    output logic                  done,
    output logic                  granted,
    output logic [SIZE_BITS-1:0]  block_offset,
    output logic [SIZE_BITS-1:0]  block_length,
    output logic [SIZE_BITS-1:0]  used_bytes,
    output logic [SIZE_BITS-1:0]  free_bytes,
    input  logic                  cfg_we,
    input  aba_pkg::cfg_idx_t     cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);
    import aba_pkg::*;

    // Widths derived from the parameters.
    localparam int MAXSL = (SIZE_BITS > LCM_W) ? SIZE_BITS : LCM_W;
    localparam int NW    = MAXSL + 2;                              // padded offsets
    localparam int SW    = (ADDR_BITS > NW) ? ADDR_BITS : NW;      // address sums
    localparam int AW    = ((SIZE_BITS > CHUNK_W) ? SIZE_BITS : CHUNK_W) + 1;
    localparam int DW    = (ADDR_BITS > SIZE_BITS) ? ADDR_BITS : SIZE_BITS;
    localparam int CW    = $clog2(DW + 1);
    localparam int MCW   = $clog2(ALIGN_W);

    // Sequencer states.
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_GCD    = 4'd1;
    localparam logic [3:0] S_LDIV   = 4'd2;
    localparam logic [3:0] S_LMUL   = 4'd3;
    localparam logic [3:0] S_PAD    = 4'd4;
    localparam logic [3:0] S_REQ    = 4'd5;
    localparam logic [3:0] S_FIT    = 4'd6;
    localparam logic [3:0] S_GMOD   = 4'd7;
    localparam logic [3:0] S_FSTART = 4'd8;
    localparam logic [3:0] S_FREE   = 4'd9;

    logic [3:0]           state_reg, state_next;
    logic [ADDR_BITS-1:0] base_reg;
    logic [SIZE_BITS-1:0] cap_reg;
    chunk_t               chunk_reg;
    logic [SIZE_BITS-1:0] used_reg, used_next;

    action_t              act_reg, act_next;
    logic [SIZE_BITS-1:0] req_reg, req_next;
    align_t               align_reg, align_next;
    align_t               q_reg, q_next;
    logic [MCW-1:0]       mcnt_reg, mcnt_next;
    lcm_t                 use_reg, use_next;
    logic [NW-1:0]        nxt_reg, nxt_next;
    logic [AW-1:0]        add_reg, add_next;
    logic                 pad2_reg, pad2_next;
    logic                 gcd_go_reg, gcd_go_next;
    logic                 div_go_reg, div_go_next;
    logic                 done_reg, done_next;

    logic                 granted_reg, granted_next;
    logic [SIZE_BITS-1:0] offset_reg, offset_next;
    logic [SIZE_BITS-1:0] length_reg, length_next;
    logic [SIZE_BITS-1:0] free_reg, free_next;

    // Unit connections.
    logic                 gcd_done;
    align_t               gcd_g;
    logic                 div_done;
    logic [DW-1:0]        div_quot;
    lcm_t                 div_rem;
    logic [DW-1:0]        div_dvd;
    lcm_t                 div_dvs;
    logic [CW-1:0]        div_len;

    logic                 accept;
    logic                 usable;
    logic [ADDR_BITS-1:0] pad_addr;
    logic [ADDR_BITS-1:0] gmod_addr;
    logic [SIZE_BITS-1:0] room;
    lcm_t                 pad;
    logic [NW-1:0]        fit_sum;

    assign accept = start && (state_reg == S_IDLE);
    assign usable = (cap_reg != '0) && (chunk_reg != '0);

    // Addresses whose residue against the alignment unit is wanted; they wrap
    // at the address width.
    assign pad_addr  = ADDR_BITS'(SW'(base_reg) + SW'(used_reg));
    assign gmod_addr = ADDR_BITS'(SW'(base_reg) + SW'(nxt_reg));
    assign room      = cap_reg - used_reg;

    // Padding up to the next multiple of the alignment unit.
    assign pad     = (div_rem != '0) ? (use_reg - div_rem) : '0;
    assign fit_sum = nxt_reg + NW'(add_reg);

    aba_gcd u_gcd
    (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (gcd_go_reg),
        .a     (align_reg),
        .b     (chunk_reg),
        .done  (gcd_done),
        .g     (gcd_g)
    );

    aba_serial_div
    #(
        .DW (DW),
        .RW (LCM_W)
    )
    u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (div_go_reg),
        .len       (div_len),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // The divider operands follow the waiting state; they are sampled in the
    // cycle in which div_go_reg is high.
    always_comb
    begin
        div_dvd = '0;
        div_dvs = '0;
        div_len = '0;
        case (state_reg)
            S_LDIV:
            begin
                div_dvd = DW'(align_reg) << (DW - ALIGN_W);
                div_dvs = LCM_W'(gcd_g);
                div_len = CW'(ALIGN_W);
            end
            S_PAD:
            begin
                div_dvd = DW'(pad_addr) << (DW - ADDR_BITS);
                div_dvs = use_reg;
                div_len = CW'(ADDR_BITS);
            end
            S_GMOD:
            begin
                div_dvd = DW'(gmod_addr) << (DW - ADDR_BITS);
                div_dvs = use_reg;
                div_len = CW'(ADDR_BITS);
            end
            S_REQ:
            begin
                div_dvd = DW'(req_reg) << (DW - SIZE_BITS);
                div_dvs = LCM_W'(chunk_reg);
                div_len = CW'(SIZE_BITS);
            end
            S_FREE:
            begin
                div_dvd = DW'(room) << (DW - SIZE_BITS);
                div_dvs = LCM_W'(chunk_reg);
                div_len = CW'(SIZE_BITS);
            end
            default:
            begin
                div_dvd = '0;
            end
        endcase
    end

    // Request sequencer.
    always_comb
    begin
        state_next   = state_reg;
        used_next    = used_reg;
        act_next     = act_reg;
        req_next     = req_reg;
        align_next   = align_reg;
        q_next       = q_reg;
        mcnt_next    = mcnt_reg;
        use_next     = use_reg;
        nxt_next     = nxt_reg;
        add_next     = add_reg;
        pad2_next    = pad2_reg;
        gcd_go_next  = 1'b0;
        div_go_next  = 1'b0;
        done_next    = 1'b0;
        granted_next = granted_reg;
        offset_next  = offset_reg;
        length_next  = length_reg;
        free_next    = free_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    act_next     = action;
                    req_next     = request_bytes;
                    // An alignment of zero behaves as one.
                    align_next   = (align_bytes == '0) ? ALIGN_W'(1) : align_bytes;
                    granted_next = 1'b0;
                    offset_next  = '0;
                    length_next  = '0;
                    pad2_next    = 1'b0;
                    state_next   = S_FSTART;
                    case (action)
                        ACT_APPEND:
                        begin
                            if (usable && (request_bytes != '0))
                            begin
                                gcd_go_next = 1'b1;
                                state_next  = S_GCD;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            used_next    = '0;
                            granted_next = 1'b1;
                        end
                        ACT_CLEAR_ALIGNED:
                        begin
                            used_next = '0;
                            if (usable)
                            begin
                                gcd_go_next = 1'b1;
                                state_next  = S_GCD;
                            end
                        end
                        default:
                        begin
                            state_next = S_FSTART;
                        end
                    endcase
                end
            end

            S_GCD:
            begin
                if (gcd_done)
                begin
                    div_go_next = 1'b1;
                    state_next  = S_LDIV;
                end
            end

            S_LDIV:
            begin
                if (div_done)
                begin
                    q_next     = div_quot[ALIGN_W-1:0];
                    use_next   = '0;
                    mcnt_next  = '0;
                    state_next = S_LMUL;
                end
            end

            // lcm = (align / gcd) * chunk, one multiplier bit per cycle, MSB first.
            S_LMUL:
            begin
                use_next  = (use_reg << 1) + (q_reg[ALIGN_W-1] ? LCM_W'(chunk_reg) : '0);
                q_next    = q_reg << 1;
                mcnt_next = mcnt_reg + 1'b1;
                if (mcnt_reg == MCW'(ALIGN_W - 1))
                begin
                    div_go_next = 1'b1;
                    state_next  = S_PAD;
                end
            end

            S_PAD:
            begin
                if (div_done)
                begin
                    if (act_reg == ACT_APPEND)
                    begin
                        nxt_next    = NW'(used_reg) + NW'(pad);
                        div_go_next = 1'b1;
                        state_next  = S_REQ;
                    end
                    else if (!pad2_reg)
                    begin
                        // Leading bytes skipped so that the first block is
                        // aligned, kept only when they leave room in the pool.
                        if ((pad != '0) && (NW'(pad) < NW'(cap_reg)))
                        begin
                            used_next = SIZE_BITS'(pad);
                        end
                        pad2_next   = 1'b1;
                        div_go_next = 1'b1;
                    end
                    else
                    begin
                        nxt_next    = NW'(used_reg) + NW'(pad);
                        div_go_next = 1'b1;
                        state_next  = S_GMOD;
                    end
                end
            end

            // Request rounded up to whole chunks.
            S_REQ:
            begin
                if (div_done)
                begin
                    if (div_rem != '0)
                    begin
                        add_next = AW'(req_reg) + AW'(chunk_reg)
                                   - AW'(div_rem[CHUNK_W-1:0]);
                    end
                    else
                    begin
                        add_next = AW'(req_reg);
                    end
                    state_next = S_FIT;
                end
            end

            S_FIT:
            begin
                if (fit_sum <= NW'(cap_reg))
                begin
                    granted_next = 1'b1;
                    offset_next  = SIZE_BITS'(nxt_reg);
                    length_next  = SIZE_BITS'(add_reg);
                    used_next    = SIZE_BITS'(fit_sum);
                end
                state_next = S_FSTART;
            end

            S_GMOD:
            begin
                if (div_done)
                begin
                    granted_next = (div_rem == '0);
                    state_next   = S_FSTART;
                end
            end

            // Remaining space, rounded down to whole chunks.
            S_FSTART:
            begin
                if ((chunk_reg == '0) || (used_reg >= cap_reg))
                begin
                    free_next  = '0;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    div_go_next = 1'b1;
                    state_next  = S_FREE;
                end
            end

            S_FREE:
            begin
                if (div_done)
                begin
                    free_next  = room - SIZE_BITS'(div_rem);
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            base_reg   <= '0;
            cap_reg    <= '0;
            chunk_reg  <= '0;
            used_reg   <= '0;
            gcd_go_reg <= 1'b0;
            div_go_reg <= 1'b0;
            done_reg   <= 1'b0;
            pad2_reg   <= 1'b0;
            mcnt_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            used_reg   <= used_next;
            gcd_go_reg <= gcd_go_next;
            div_go_reg <= div_go_next;
            done_reg   <= done_next;
            pad2_reg   <= pad2_next;
            mcnt_reg   <= mcnt_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_BASE:     base_reg  <= cfg_data[ADDR_BITS-1:0];
                    REG_CAPACITY: cap_reg   <= cfg_data[SIZE_BITS-1:0];
                    REG_CHUNK:    chunk_reg <= cfg_data[CHUNK_W-1:0];
                    default:      base_reg  <= base_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg     <= act_next;
        req_reg     <= req_next;
        align_reg   <= align_next;
        q_reg       <= q_next;
        use_reg     <= use_next;
        nxt_reg     <= nxt_next;
        add_reg     <= add_next;
        granted_reg <= granted_next;
        offset_reg  <= offset_next;
        length_reg  <= length_next;
        free_reg    <= free_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign granted      = granted_reg;
    assign block_offset = offset_reg;
    assign block_length = length_reg;
    assign used_bytes   = used_reg;
    assign free_bytes   = free_reg;

endmodule
